>>> src/weighted_box_merge_defines.svh
`ifndef WEIGHTED_BOX_MERGE_DEFINES_SVH
`define WEIGHTED_BOX_MERGE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define WBM_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define WBM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/wbm_pkg.sv
`timescale 1ns / 1ps
package wbm_pkg;

   localparam int MAX_BOXES_DEF = 64;
   localparam int COORD_W       = 13;
   localparam int CLASS_W       = 7;
   localparam int SCORE_W       = 16;
   localparam int SUM_W         = 36;
   localparam int ACC_W         = 23;
   localparam int OUT_SCORE_W   = 22;
   localparam int DIV_STEPS     = 36;
   localparam logic [SCORE_W-1:0] THRESH_RESET = 16'd32768;
   localparam logic REG_IOU_THRESH = 1'b0;

   typedef struct packed {
      logic signed [COORD_W-1:0] lx;
      logic signed [COORD_W-1:0] ty;
      logic signed [COORD_W-1:0] rx;
      logic signed [COORD_W-1:0] by;
   } box_type;

   typedef struct packed {
      logic                      start;
      logic signed [SUM_W-1:0]   dividend;
      logic        [ACC_W-1:0]   divisor;
   } div_req_type;

   typedef enum logic [3:0] {
      S_IDLE, S_G_RD, S_G_CHK, S_C_RD, S_C_DATA, S_C_WAIT,
      S_A_START, S_A_RD, S_A_DATA, S_A_ADD,
      S_D_GO, S_D_WAIT, S_EMIT, S_OUT
   } state_type;

endpackage

>>> src/wbm_ram.sv
`timescale 1ns / 1ps
module wbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/wbm_iou.sv
`timescale 1ns / 1ps
module wbm_iou import wbm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  box_type            lead,
   input  box_type            cand,
   input  logic [SCORE_W-1:0] thresh,
   output logic               out_valid,
   output logic               merge
);

   // stage 1: extents
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic               d1_ff, d2_ff, d3_ff, d4_ff;
   logic signed [13:0] iw_ff, ih_ff, wa_ff, ha_ff, wb_ff, hb_ff;
   logic signed [13:0] iw_in, ih_in, wa_in, ha_in, wb_in, hb_in;
   logic signed [13:0] minr, maxl, minb, maxt;
   logic               d1_in;
   // stage 2: products
   logic signed [27:0] inter_ff, aa_ff, ab_ff;
   // stage 3: union
   logic signed [29:0] uni_ff, uni4_ff, uni_in;
   logic signed [43:0] lhs_ff, lhs4_ff;
   // stage 4: threshold product
   logic signed [16:0] thr_s;
   logic signed [46:0] rhs_ff;
   logic signed [47:0] lhs_x, rhs_x;

   always_comb begin
      minr  = (lead.rx < cand.rx) ? {lead.rx[12], lead.rx} : {cand.rx[12], cand.rx};
      maxl  = (lead.lx > cand.lx) ? {lead.lx[12], lead.lx} : {cand.lx[12], cand.lx};
      minb  = (lead.by < cand.by) ? {lead.by[12], lead.by} : {cand.by[12], cand.by};
      maxt  = (lead.ty > cand.ty) ? {lead.ty[12], lead.ty} : {cand.ty[12], cand.ty};
      iw_in = minr - maxl;
      ih_in = minb - maxt;
      wa_in = {lead.rx[12], lead.rx} - {lead.lx[12], lead.lx};
      ha_in = {lead.by[12], lead.by} - {lead.ty[12], lead.ty};
      wb_in = {cand.rx[12], cand.rx} - {cand.lx[12], cand.lx};
      hb_in = {cand.by[12], cand.by} - {cand.ty[12], cand.ty};
      d1_in = (lead.ty > cand.by) || (cand.ty > lead.by) ||
              (lead.lx > cand.rx) || (cand.lx > lead.rx);
      uni_in = {{2{aa_ff[27]}}, aa_ff} + {{2{ab_ff[27]}}, ab_ff} -
               {{2{inter_ff[27]}}, inter_ff};
      thr_s  = {1'b0, thresh};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      iw_ff    <= iw_in;
      ih_ff    <= ih_in;
      wa_ff    <= wa_in;
      ha_ff    <= ha_in;
      wb_ff    <= wb_in;
      hb_ff    <= hb_in;
      d1_ff    <= d1_in;
      inter_ff <= iw_ff * ih_ff;
      aa_ff    <= wa_ff * ha_ff;
      ab_ff    <= wb_ff * hb_ff;
      d2_ff    <= d1_ff;
      uni_ff   <= uni_in;
      lhs_ff   <= {inter_ff, 16'b0};
      d3_ff    <= d2_ff;
      rhs_ff   <= thr_s * uni_ff;
      uni4_ff  <= uni_ff;
      lhs4_ff  <= lhs_ff;
      d4_ff    <= d3_ff;
   end

   always_comb begin
      lhs_x = {{4{lhs4_ff[43]}}, lhs4_ff};
      rhs_x = {rhs_ff[46], rhs_ff};
      merge = !d4_ff && (uni4_ff != '0) &&
              (uni4_ff[29] ? (lhs_x < rhs_x) : (lhs_x > rhs_x));
   end

   assign out_valid = v4_ff;

endmodule

>>> src/wbm_div.sv
`timescale 1ns / 1ps
module wbm_div import wbm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  div_req_type        req,
   output logic               done,
   output logic [COORD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_STEPS + 1);

   logic             busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [ACC_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W:0]   trial;
   logic [ACC_W+1:0] diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      diff    = {1'b0, trial} - {2'b0, req.divisor};
      ge      = !diff[ACC_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (req.start) begin
         neg_in  = req.dividend[SUM_W-1];
         quo_in  = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : req.dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? COORD_W'(-quo_ff[COORD_W-1:0]) : quo_ff[COORD_W-1:0];

endmodule

>>> src/weighted_box_merge.sv
`timescale 1ns / 1ps
// Weighted box merge.
// req_* channel: one detection box per transfer (corners, class, score). The
// transfer with req_final_box set closes the list and starts the merge. Up to
// MAX_BOXES boxes are kept; later ones are dropped, a dropped final box still
// starts the merge. Boxes are loaded at one per cycle while idle.
// rsp_* channel: one merged box per group, in group order; rsp_last_group
// marks the last one. After the merge starts req_stall stays high until the
// last result has been transferred.
// Each IoU test runs through a four-stage pipeline after a registered memory
// read, the per-group sums scan the box memories once, and each of the four
// corners goes through a shared 36-step divider unless the group's score sum
// is zero.
// A stalled result holds in the output register; the merge waits for it.
// Reset (synchronous) empties the list, drops any merge in progress and sets
// the IoU threshold to 0.5. Threshold register at CSR address 0.
`include "weighted_box_merge_defines.svh"
module weighted_box_merge import wbm_pkg::*; #(
   parameter int MAX_BOXES = MAX_BOXES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_left_x,
   input  logic signed [COORD_W-1:0] req_top_y,
   input  logic signed [COORD_W-1:0] req_right_x,
   input  logic signed [COORD_W-1:0] req_bottom_y,
   input  logic [CLASS_W-1:0]        req_class_id,
   input  logic [SCORE_W-1:0]        req_score,
   input  logic                      req_final_box,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_merged_left_x,
   output logic signed [COORD_W-1:0] rsp_merged_top_y,
   output logic signed [COORD_W-1:0] rsp_merged_right_x,
   output logic signed [COORD_W-1:0] rsp_merged_bottom_y,
   output logic [CLASS_W-1:0]        rsp_merged_class,
   output logic [OUT_SCORE_W-1:0]    rsp_score_sum,
   output logic                      rsp_last_group,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [2:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int AW = $clog2(MAX_BOXES);
   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam int BOX_W = 4 * COORD_W;
   localparam int CS_W = CLASS_W + SCORE_W;

   state_type state_ff, state_in;

   logic [SCORE_W-1:0] thr_ff, thr_in;
   logic [CW-1:0] cnt_ff, cnt_in, gcnt_ff, gcnt_in, i_ff, i_in, j_ff, j_in;
   logic [CW-1:0] gid_ff, gid_in, og_ff, og_in;
   box_type lead_ff, lead_in;
   logic [CLASS_W-1:0] lcls_ff, lcls_in;
   logic found_ff, found_in, ceq_ff, ceq_in;
   logic signed [SUM_W-1:0] sums_ff [4];
   logic signed [SUM_W-1:0] sums_in [4];
   logic signed [29:0] prod_ff [4];
   logic signed [29:0] prod_in [4];
   logic [SCORE_W-1:0] sc_ff, sc_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [1:0] c_ff, c_in;
   logic [COORD_W-1:0] res_ff [4];
   logic [COORD_W-1:0] res_in [4];
   logic rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] o_lx_ff, o_ty_ff, o_rx_ff, o_by_ff;
   logic [COORD_W-1:0] o_lx_in, o_ty_in, o_rx_in, o_by_in;
   logic [CLASS_W-1:0] o_cls_ff, o_cls_in;
   logic [OUT_SCORE_W-1:0] o_sum_ff, o_sum_in;
   logic o_last_ff, o_last_in;

   logic req_xfer, csr_wr;
   logic box_we, grp_we;
   logic [AW-1:0] box_waddr, grp_waddr, rd_addr;
   logic [CW-1:0] grp_wdata, grp_rd;
   logic [BOX_W-1:0] box_rd;
   logic [CS_W-1:0] cs_rd;
   box_type cand;
   logic iou_in_valid, iou_valid, iou_merge;
   div_req_type div_req;
   logic div_done;
   logic [COORD_W-1:0] div_q;
   logic [CW-1:0] i_nx, j_nx;
   logic signed [COORD_W-1:0] lead_c [4];
   logic signed [COORD_W-1:0] cand_c [4];

   assign req_stall  = (state_ff != S_IDLE);
   assign req_xfer   = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_IOU_THRESH);
   assign csr_prdata = (csr_paddr[2] == REG_IOU_THRESH) ? {16'b0, thr_ff} : 32'b0;

   assign cand   = box_type'(box_rd);
   assign i_nx   = i_ff + 1'b1;
   assign j_nx   = j_ff + 1'b1;
   assign lead_c = '{lead_ff.lx, lead_ff.ty, lead_ff.rx, lead_ff.by};
   assign cand_c = '{cand.lx, cand.ty, cand.rx, cand.by};

   wbm_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
      .clock(clock), .wr_en(box_we), .wr_addr(box_waddr),
      .wr_data({req_left_x, req_top_y, req_right_x, req_bottom_y}),
      .rd_addr(rd_addr), .rd_data(box_rd)
   );

   wbm_ram #(.WIDTH(CS_W), .DEPTH(MAX_BOXES)) u_cs_ram (
      .clock(clock), .wr_en(box_we), .wr_addr(box_waddr),
      .wr_data({req_class_id, req_score}),
      .rd_addr(rd_addr), .rd_data(cs_rd)
   );

   wbm_ram #(.WIDTH(CW), .DEPTH(MAX_BOXES)) u_grp_ram (
      .clock(clock), .wr_en(grp_we), .wr_addr(grp_waddr),
      .wr_data(grp_wdata), .rd_addr(rd_addr), .rd_data(grp_rd)
   );

   wbm_iou u_iou (
      .clock(clock), .reset(reset), .in_valid(iou_in_valid),
      .lead(lead_ff), .cand(cand), .thresh(thr_ff),
      .out_valid(iou_valid), .merge(iou_merge)
   );

   wbm_div u_div (
      .clock(clock), .reset(reset), .req(div_req),
      .done(div_done), .quotient(div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_xfer && req_final_box) state_in = S_G_RD;
         S_G_RD:    state_in = S_G_CHK;
         S_G_CHK: begin
            if (i_nx == cnt_ff) state_in = S_A_START;
            else if (grp_rd != '0) state_in = S_G_RD;
            else state_in = S_C_RD;
         end
         S_C_RD:    state_in = S_C_DATA;
         S_C_DATA:  state_in = S_C_WAIT;
         S_C_WAIT: begin
            if (iou_valid) begin
               if (j_nx != cnt_ff) state_in = S_C_RD;
               else if (i_nx == cnt_ff) state_in = S_A_START;
               else state_in = S_G_RD;
            end
         end
         S_A_START: state_in = S_A_RD;
         S_A_RD:    state_in = S_A_DATA;
         S_A_DATA: begin
            if (grp_rd == og_ff) state_in = S_A_ADD;
            else if (j_nx == cnt_ff) state_in = S_D_GO;
            else state_in = S_A_RD;
         end
         S_A_ADD:   state_in = (j_nx == cnt_ff) ? S_D_GO : S_A_RD;
         S_D_GO: begin
            if (acc_ff != '0) state_in = S_D_WAIT;
            else if (c_ff == 2'd3) state_in = S_EMIT;
         end
         S_D_WAIT: begin
            if (div_done) state_in = (c_ff == 2'd3) ? S_EMIT : S_D_GO;
         end
         S_EMIT:    state_in = S_OUT;
         S_OUT: begin
            if (!rsp_stall) state_in = (og_ff == gcnt_ff) ? S_IDLE : S_A_START;
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      thr_in       = csr_wr ? csr_pwdata[SCORE_W-1:0] : thr_ff;
      cnt_in       = cnt_ff;
      gcnt_in      = gcnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      gid_in       = gid_ff;
      og_in        = og_ff;
      lead_in      = lead_ff;
      lcls_in      = lcls_ff;
      found_in     = found_ff;
      ceq_in       = ceq_ff;
      sums_in      = sums_ff;
      prod_in      = prod_ff;
      sc_in        = sc_ff;
      acc_in       = acc_ff;
      c_in         = c_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      o_lx_in      = o_lx_ff;
      o_ty_in      = o_ty_ff;
      o_rx_in      = o_rx_ff;
      o_by_in      = o_by_ff;
      o_cls_in     = o_cls_ff;
      o_sum_in     = o_sum_ff;
      o_last_in    = o_last_ff;
      box_we       = 1'b0;
      box_waddr    = cnt_ff[AW-1:0];
      grp_we       = 1'b0;
      grp_waddr    = cnt_ff[AW-1:0];
      grp_wdata    = '0;
      iou_in_valid = 1'b0;
      div_req      = '{start: 1'b0, dividend: sums_ff[c_ff], divisor: acc_ff};
      rd_addr      = (state_ff == S_G_RD) ? i_ff[AW-1:0] : j_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (cnt_ff != CW'(MAX_BOXES)) begin
                  box_we = 1'b1;
                  grp_we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req_final_box) begin
                  i_in    = '0;
                  gid_in  = '0;
                  gcnt_in = '0;
                  og_in   = CW'(1);
               end
            end
         end
         S_G_CHK: begin
            if (grp_rd != '0) begin
               i_in = i_nx;
            end else begin
               gid_in    = gid_ff + 1'b1;
               gcnt_in   = gid_ff + 1'b1;
               grp_we    = 1'b1;
               grp_waddr = i_ff[AW-1:0];
               grp_wdata = gid_ff + 1'b1;
               lead_in   = cand;
               lcls_in   = cs_rd[CS_W-1:SCORE_W];
               j_in      = i_nx;
            end
         end
         S_C_DATA: begin
            iou_in_valid = 1'b1;
            ceq_in       = (cs_rd[CS_W-1:SCORE_W] == lcls_ff);
         end
         S_C_WAIT: begin
            if (iou_valid) begin
               if (iou_merge && ceq_ff) begin
                  grp_we    = 1'b1;
                  grp_waddr = j_ff[AW-1:0];
                  grp_wdata = gid_ff;
               end
               j_in = j_nx;
               if (j_nx == cnt_ff) i_in = i_nx;
            end
         end
         S_A_START: begin
            j_in     = '0;
            acc_in   = '0;
            found_in = 1'b0;
            c_in     = '0;
            for (int k = 0; k < 4; k++) sums_in[k] = '0;
         end
         S_A_DATA: begin
            if (grp_rd == og_ff) begin
               sc_in = cs_rd[SCORE_W-1:0];
               for (int k = 0; k < 4; k++) begin
                  prod_in[k] = cand_c[k] * $signed({1'b0, cs_rd[SCORE_W-1:0]});
               end
               if (!found_ff) begin
                  found_in = 1'b1;
                  lead_in  = cand;
                  lcls_in  = cs_rd[CS_W-1:SCORE_W];
               end
            end else begin
               j_in = j_nx;
            end
         end
         S_A_ADD: begin
            for (int k = 0; k < 4; k++) begin
               sums_in[k] = sums_ff[k] + SUM_W'(prod_ff[k]);
            end
            acc_in = acc_ff + ACC_W'(sc_ff);
            j_in   = j_nx;
         end
         S_D_GO: begin
            if (acc_ff != '0) begin
               div_req.start = 1'b1;
            end else begin
               res_in[c_ff] = lead_c[c_ff];
               c_in         = c_ff + 1'b1;
            end
         end
         S_D_WAIT: begin
            if (div_done) begin
               res_in[c_ff] = div_q;
               c_in         = c_ff + 1'b1;
            end
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            o_lx_in      = res_ff[0];
            o_ty_in      = res_ff[1];
            o_rx_in      = res_ff[2];
            o_by_in      = res_ff[3];
            o_cls_in     = lcls_ff;
            o_sum_in     = acc_ff[OUT_SCORE_W-1:0];
            o_last_in    = (og_ff == gcnt_ff);
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               og_in        = og_ff + 1'b1;
               if (og_ff == gcnt_ff) cnt_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THRESH_RESET;
         cnt_ff       <= '0;
         gcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         cnt_ff       <= cnt_in;
         gcnt_ff      <= gcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      gid_ff    <= gid_in;
      og_ff     <= og_in;
      lead_ff   <= lead_in;
      lcls_ff   <= lcls_in;
      found_ff  <= found_in;
      ceq_ff    <= ceq_in;
      sums_ff   <= sums_in;
      prod_ff   <= prod_in;
      sc_ff     <= sc_in;
      acc_ff    <= acc_in;
      c_ff      <= c_in;
      res_ff    <= res_in;
      o_lx_ff   <= o_lx_in;
      o_ty_ff   <= o_ty_in;
      o_rx_ff   <= o_rx_in;
      o_by_ff   <= o_by_in;
      o_cls_ff  <= o_cls_in;
      o_sum_ff  <= o_sum_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_merged_left_x   = o_lx_ff;
   assign rsp_merged_top_y    = o_ty_ff;
   assign rsp_merged_right_x  = o_rx_ff;
   assign rsp_merged_bottom_y = o_by_ff;
   assign rsp_merged_class    = o_cls_ff;
   assign rsp_score_sum       = o_sum_ff;
   assign rsp_last_group      = o_last_ff;

   `WBM_ASSERT_IMPL(a_rsp_only_in_out, rsp_valid_ff, state_ff == S_OUT, "result shown outside output state")
   `WBM_ASSERT_IMPL(a_count_in_range, 1'b1, cnt_ff <= CW'(MAX_BOXES), "box count beyond capacity")
   `WBM_ASSERT_NEXT(a_div_advance, (state_ff == S_D_WAIT) && div_done, (state_ff == S_D_GO) || (state_ff == S_EMIT), "divider result not consumed")

endmodule
